FILE: design/sau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sau_pkg
// Shared operation codes, status codes, state encoding and the command and
// status bundles between the stack arithmetic controller and its datapath.
// ----------------------------------------------------------------------------
package sau_pkg;

   // fixed widths of the transaction fields
   localparam int unsigned OP_W        = 3;
   localparam int unsigned FIELD_W     = 32;
   localparam int unsigned DEPTH_OUT_W = 7;
   localparam int unsigned EXT_W       = 64;

   // operation codes, the two top codes are ignored
   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
   localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
   localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
   localparam logic [OP_W-1:0] OP_MOD  = 3'd5;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_SHORT   = 2'd1,
      ST_DIVZERO = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_LOAD,
      S_ITER,
      S_FINISH
   } state_type;

   // operations of the iterative multiply / divide unit
   typedef enum logic [1:0] {
      UOP_MUL,
      UOP_DIV,
      UOP_REM
   } uop_type;

   typedef struct packed {
      logic       capture;
      logic       do_push;
      logic       rd_issue;
      logic       alu_write;
      logic       unit_start;
      logic       unit_write;
      logic       set_status;
      status_type status_code;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic op_push;
      logic op_arith;
      logic op_addsub;
      logic op_divmod;
      logic stack_full;
      logic stack_short;
      logic div_zero;
      logic unit_done;
      logic out_free;
   } sts_type;

endpackage

FILE: design/sau_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sau_muldiv
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
// Division works on magnitudes and fixes the signs at the output.
// ----------------------------------------------------------------------------
module sau_muldiv
   import sau_pkg::*;
#(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  uop_type               uop,
   input  logic [DATA_WIDTH-1:0] opa,
   input  logic [DATA_WIDTH-1:0] opb,
   output logic                  done,
   output logic [DATA_WIDTH-1:0] result
);

   localparam int unsigned CNT_W = $clog2(DATA_WIDTH + 1);

   logic                  busy_ff, busy_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   uop_type               uop_ff, uop_in;
   logic                  neg_q_ff, neg_q_in;
   logic                  neg_r_ff, neg_r_in;
   logic [DATA_WIDTH-1:0] x_ff, x_in;
   logic [DATA_WIDTH-1:0] y_ff, y_in;
   logic [DATA_WIDTH-1:0] z_ff, z_in;
   logic [DATA_WIDTH-1:0] mag_a, mag_b;
   logic [DATA_WIDTH:0]   shifted, diff;

   // operand magnitudes and one restoring step
   always_comb begin
      mag_a   = opa[DATA_WIDTH-1] ? (~opa + DATA_WIDTH'(1)) : opa;
      mag_b   = opb[DATA_WIDTH-1] ? (~opb + DATA_WIDTH'(1)) : opb;
      shifted = {z_ff, x_ff[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, y_ff};
   end

   // x: multiplier / dividend-quotient, y: multiplicand / divisor,
   // z: product accumulator / partial remainder
   always_comb begin
      busy_in  = busy_ff;
      cnt_in   = cnt_ff;
      uop_in   = uop_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DATA_WIDTH);
         uop_in  = uop;
         z_in    = '0;
         if (uop == UOP_MUL) begin
            x_in     = opa;
            y_in     = opb;
            neg_q_in = 1'b0;
            neg_r_in = 1'b0;
         end else begin
            x_in     = mag_a;
            y_in     = mag_b;
            neg_q_in = opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
            neg_r_in = opa[DATA_WIDTH-1];
         end
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
            if (uop_ff == UOP_MUL) begin
               if (x_ff[0]) begin
                  z_in = z_ff + y_ff;
               end
               y_in = y_ff << 1;
               x_in = x_ff >> 1;
            end else begin
               z_in = diff[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
               x_in = {x_ff[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      uop_ff   <= uop_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
   end

   // result with the sign fix for quotient and remainder
   always_comb begin
      done = busy_ff && (cnt_ff == '0);
      case (uop_ff)
         UOP_MUL: result = z_ff;
         UOP_DIV: result = neg_q_ff ? (~x_ff + DATA_WIDTH'(1)) : x_ff;
         UOP_REM: result = neg_r_ff ? (~z_ff + DATA_WIDTH'(1)) : z_ff;
         default: result = '0;
      endcase
   end

endmodule

FILE: design/sau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sau_datapath
// Stack memory with the top entry cached in a register, add/sub logic, the
// iterative multiply/divide unit and the result output register.
// ----------------------------------------------------------------------------
module sau_datapath
   import sau_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 64,
   parameter int unsigned DATA_WIDTH  = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output sts_type                 sts,
   input  logic [OP_W-1:0]         req_operation,
   input  logic signed [FIELD_W-1:0] req_push_value,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic signed [FIELD_W-1:0] rsp_top_value,
   output logic [DEPTH_OUT_W-1:0]  rsp_stack_depth
);

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   // request capture
   logic [OP_W-1:0]           op_ff, op_in;
   logic signed [FIELD_W-1:0] push_ff, push_in;

   // stack state: entries below the top live in memory, the top in a register
   logic [CW-1:0]         count_ff, count_in;
   logic [DATA_WIDTH-1:0] top_ff, top_in;
   logic [DATA_WIDTH-1:0] stack_mem [STACK_DEPTH];
   logic [DATA_WIDTH-1:0] mem_q_ff;
   status_type            status_ff, status_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                out_status_ff, out_status_in;
   logic signed [FIELD_W-1:0] out_top_ff, out_top_in;
   logic [DEPTH_OUT_W-1:0]    out_depth_ff, out_depth_in;

   logic [CW-1:0]             count_m1, count_m2;
   logic [DATA_WIDTH-1:0]     push_ext, alu_res, unit_result;
   logic signed [EXT_W-1:0]   top_wide;
   logic [EXT_W-1:0]          count_wide;
   logic                      unit_done;
   uop_type                   unit_op;

   // operand preparation
   always_comb begin
      count_m1   = count_ff - CW'(1);
      count_m2   = count_ff - CW'(2);
      push_ext   = DATA_WIDTH'(EXT_W'(push_ff));
      alu_res    = (op_ff == OP_SUB) ? (mem_q_ff - top_ff) : (mem_q_ff + top_ff);
      top_wide   = EXT_W'(signed'(top_ff));
      count_wide = EXT_W'(count_ff);
      case (op_ff)
         OP_MUL:  unit_op = UOP_MUL;
         OP_MOD:  unit_op = UOP_REM;
         default: unit_op = UOP_DIV;
      endcase
   end

   sau_muldiv #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.unit_start),
      .uop    (unit_op),
      .opa    (mem_q_ff),
      .opb    (top_ff),
      .done   (unit_done),
      .result (unit_result)
   );

   // status toward the controller
   always_comb begin
      sts.op_push     = (op_ff == OP_PUSH);
      sts.op_addsub   = (op_ff == OP_ADD) || (op_ff == OP_SUB);
      sts.op_divmod   = (op_ff == OP_DIV) || (op_ff == OP_MOD);
      sts.op_arith    = sts.op_addsub || sts.op_divmod || (op_ff == OP_MUL);
      sts.stack_full  = (count_ff == CW'(STACK_DEPTH));
      sts.stack_short = (count_ff < CW'(2));
      sts.div_zero    = (top_ff == '0);
      sts.unit_done   = unit_done;
      sts.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // next values of the stack and capture registers
   always_comb begin
      op_in     = op_ff;
      push_in   = push_ff;
      count_in  = count_ff;
      top_in    = top_ff;
      status_in = status_ff;
      if (cmd.capture) begin
         op_in     = req_operation;
         push_in   = req_push_value;
         status_in = ST_OK;
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.do_push) begin
         count_in = count_ff + CW'(1);
         top_in   = push_ext;
      end else if (cmd.alu_write) begin
         count_in = count_m1;
         top_in   = alu_res;
      end else if (cmd.unit_write) begin
         count_in = count_m1;
         top_in   = unit_result;
      end
   end

   // next values of the output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      out_status_in = out_status_ff;
      out_top_in    = out_top_ff;
      out_depth_in  = out_depth_ff;
      if (cmd.out_load) begin
         rsp_valid_in  = 1'b1;
         out_status_in = status_ff;
         out_top_in    = (count_ff != '0) ? top_wide[FIELD_W-1:0] : '0;
         out_depth_in  = count_wide[DEPTH_OUT_W-1:0];
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      push_ff       <= push_in;
      top_ff        <= top_in;
      status_ff     <= status_in;
      out_status_ff <= out_status_in;
      out_top_ff    <= out_top_in;
      out_depth_ff  <= out_depth_in;
   end

   // stack memory: old top spills on push, second entry read for arithmetic
   always_ff @(posedge clock) begin
      if (cmd.do_push && (count_ff != '0)) begin
         stack_mem[count_m1[AW-1:0]] <= top_ff;
      end
      if (cmd.rd_issue) begin
         mem_q_ff <= stack_mem[count_m2[AW-1:0]];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_top_value   = out_top_ff;
   assign rsp_stack_depth = out_depth_ff;

`ifndef SYNTH
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("entry count above stack depth");

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      cmd.do_push |-> !sts.stack_full)
      else $error("push onto a full stack");

   a_pop_two : assert property (@(posedge clock) disable iff (reset)
      (cmd.alu_write || cmd.unit_write) |-> !sts.stack_short)
      else $error("arithmetic write with fewer than two entries");
`endif

endmodule

FILE: design/sau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sau_ctrl
// Controller state machine: takes one transaction at a time, sequences the
// stack checks, memory read, arithmetic and the result hand-off.
// ----------------------------------------------------------------------------
module sau_ctrl
   import sau_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output cmd_type cmd,
   input  sts_type sts
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.op_push) begin
               if (sts.stack_full) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_FULL;
               end else begin
                  cmd.do_push = 1'b1;
               end
               state_in = S_FINISH;
            end else if (sts.op_arith) begin
               if (sts.stack_short) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = ST_SHORT;
                  state_in        = S_FINISH;
               end else begin
                  cmd.rd_issue = 1'b1;
                  state_in     = S_LOAD;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_LOAD: begin
            if (sts.op_divmod && sts.div_zero) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_DIVZERO;
               state_in        = S_FINISH;
            end else if (sts.op_addsub) begin
               cmd.alu_write = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.unit_start = 1'b1;
               state_in       = S_ITER;
            end
         end
         S_ITER: begin
            if (sts.unit_done) begin
               cmd.unit_write = 1'b1;
               state_in       = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_out_free : assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded over an untaken result");

   a_unit_write : assert property (@(posedge clock) disable iff (reset)
      cmd.unit_write |-> sts.unit_done)
      else $error("unit result taken before the unit finished");

   a_capture_next : assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == S_CHECK) && req_stall)
      else $error("captured transaction not followed by the check step");
`endif

endmodule

FILE: design/stack_arithmetic_unit_core.sv
`timescale 1ns / 1ps
// Sequence: push, too-short and ignored codes go from S_CHECK to S_FINISH; add/sub and
//   zero divisor pass S_LOAD as well; mul/div/mod also wait in S_ITER for the unit.
// Throughput: one transaction at a time; the next is accepted once S_FINISH has loaded
//   the result register, which waits while rsp_stall holds an untaken result; mul/div/mod
//   run through the one-bit-per-cycle multiply/divide unit.
// Reset: synchronous; clears the entry count, controller and output valid.
// ----------------------------------------------------------------------------
// stack_arithmetic_unit_core
// Bounded stack of signed integers with push, add, sub, mul, div and mod
// on the top two entries, reporting status, new top and depth per transaction.
// ----------------------------------------------------------------------------
module stack_arithmetic_unit_core
   import sau_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 64,
   parameter int unsigned DATA_WIDTH  = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [OP_W-1:0]           req_operation,
   input  logic signed [FIELD_W-1:0] req_push_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic signed [FIELD_W-1:0] rsp_top_value,
   output logic [DEPTH_OUT_W-1:0]    rsp_stack_depth
);

   cmd_type cmd;
   sts_type sts;

   // controller
   sau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // datapath
   sau_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_operation),
      .req_push_value  (req_push_value),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_top_value   (rsp_top_value),
      .rsp_stack_depth (rsp_stack_depth)
   );

endmodule

FILE: sim/stack_arithmetic_unit_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_arithmetic_unit_core_tb
// Self-checking bench for the stack arithmetic unit. A scoreboard keeps its
// own copy of the stack, predicts status, top and depth for every accepted
// request and checks each response in order. Directed corners come first,
// then fill and drain sequences with random operands under several idling
// and stall mixes on both channels.
// ----------------------------------------------------------------------------
module stack_arithmetic_unit_core_tb;
   import sau_pkg::*;

   localparam int unsigned STACK_ENTRIES = 64;
   localparam int unsigned QUIET_LIMIT   = 2000;
   localparam int unsigned TAIL_CYCLES   = 60;
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
   localparam logic signed [FIELD_W-1:0] MAX_VAL = 32'sh7fff_ffff;
   localparam logic signed [FIELD_W-1:0] MIN_VAL = 32'sh8000_0000;

   // one response transaction
   typedef struct {
      status_type                status;
      logic signed [FIELD_W-1:0] top;
      logic [DEPTH_OUT_W-1:0]    depth;
   } stack_rsp_type;

   // stack model and in-order response checker
   class stack_scoreboard;
      logic signed [FIELD_W-1:0] entries [STACK_ENTRIES];
      int unsigned               entry_total;
      int unsigned               max_seen;
      stack_rsp_type             pending_results [$];
      int unsigned               error_count;
      int unsigned               checked_count;
      int unsigned               op_hits [8];
      int unsigned               status_hits [4];

      function void note_transaction(logic [OP_W-1:0] op,
                                     logic signed [FIELD_W-1:0] value);
         stack_rsp_type             want;
         logic signed [FIELD_W-1:0] lhs;
         logic signed [FIELD_W-1:0] rhs;
         logic signed [FIELD_W-1:0] res;
         bit                        commit;
         want.status = ST_OK;
         commit      = 1'b0;
         op_hits[op]++;
         if (op == OP_PUSH) begin
            if (entry_total == STACK_ENTRIES) begin
               want.status = ST_FULL;
            end else begin
               entries[entry_total] = value;
               entry_total++;
            end
         end else if (op <= OP_MOD) begin
            if (entry_total < 2) begin
               want.status = ST_SHORT;
            end else begin
               rhs    = entries[entry_total-1];
               lhs    = entries[entry_total-2];
               commit = 1'b1;
               case (op)
                  OP_ADD: res = lhs + rhs;
                  OP_SUB: res = lhs - rhs;
                  OP_MUL: res = lhs * rhs;
                  default: begin
                     // 64-bit math keeps MIN / -1 well defined, then truncate
                     if (rhs == 0) begin
                        want.status = ST_DIVZERO;
                        commit      = 1'b0;
                     end else if (op == OP_DIV) begin
                        res = longint'(lhs) / longint'(rhs);
                     end else begin
                        res = longint'(lhs) % longint'(rhs);
                     end
                  end
               endcase
               if (commit) begin
                  entries[entry_total-2] = res;
                  entry_total--;
               end
            end
         end
         if (entry_total > max_seen) max_seen = entry_total;
         want.top   = (entry_total > 0) ? entries[entry_total-1] : '0;
         want.depth = entry_total[DEPTH_OUT_W-1:0];
         pending_results.push_back(want);
      endfunction

      function void check_response(logic [1:0] status,
                                   logic signed [FIELD_W-1:0] top,
                                   logic [DEPTH_OUT_W-1:0] depth);
         stack_rsp_type want;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response, status %0d top %0d depth %0d",
                     $time, status, top, depth);
            error_count++;
            return;
         end
         want = pending_results.pop_front();
         checked_count++;
         status_hits[status]++;
         if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
            error_count++;
         end
         if (top !== want.top) begin
            $display("%0t: top mismatch, expected %0d, actual %0d",
                     $time, want.top, top);
            error_count++;
         end
         if (depth !== want.depth) begin
            $display("%0t: depth mismatch, expected %0d, actual %0d",
                     $time, want.depth, depth);
            error_count++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [OP_W-1:0]           req_operation = OP_PUSH;
   logic signed [FIELD_W-1:0] req_push_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [1:0]                rsp_status;
   logic signed [FIELD_W-1:0] rsp_top_value;
   logic [DEPTH_OUT_W-1:0]    rsp_stack_depth;

   stack_scoreboard board;
   int unsigned     send_idle_pct = 0;
   int unsigned     stall_pct     = 0;
   int unsigned     quiet_cycles  = 0;

   stack_arithmetic_unit_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_top_value   (rsp_top_value),
      .rsp_stack_depth (rsp_stack_depth)
   );

   // clock generation
   initial begin
      forever #10 clock = ~clock;
   end

   // response side back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   // transaction monitors on both channels
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         board.note_transaction(req_operation, req_push_value);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_response(rsp_status, rsp_top_value, rsp_stack_depth);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
         $display("stack_arithmetic_unit_core_tb NOT OK");
         $finish;
      end
   end

   // send one request, holding it until accepted; valid stays high afterwards
   task automatic send_request(input logic [OP_W-1:0] op,
                               input logic signed [FIELD_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_push_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // operand mix: corners, small values for division, full-range random
   function automatic logic signed [FIELD_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0:       return '0;
               1:       return 32'sd1;
               2:       return -32'sd1;
               3:       return MIN_VAL;
               default: return MAX_VAL;
            endcase
         end
         1, 2:    return $signed($urandom_range(0, 40)) - 32'sd20;
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_arith();
      case ($urandom_range(0, 4))
         0:       return OP_ADD;
         1:       return OP_SUB;
         2:       return OP_DIV;
         3:       return OP_MUL;
         default: return OP_MOD;
      endcase
   endfunction

   initial begin
      int unsigned fill_len;
      int unsigned roll;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_request(OP_ADD, '0);          // too short on empty stack
      send_request(OP_SPARE_LO, MAX_VAL); // ignored code on empty stack
      send_request(OP_PUSH, MAX_VAL);
      send_request(OP_DIV, '0);           // too short with one entry
      send_request(OP_PUSH, 32'sd1);
      send_request(OP_ADD, '0);           // wraps to most negative
      send_request(OP_PUSH, -32'sd1);
      send_request(OP_DIV, '0);           // most negative / -1
      send_request(OP_PUSH, -32'sd1);
      send_request(OP_MOD, '0);           // most negative mod -1
      send_request(OP_PUSH, '0);
      send_request(OP_DIV, '0);           // zero divisor
      send_request(OP_MOD, '0);           // zero divisor
      send_request(OP_PUSH, -32'sd7);
      send_request(OP_PUSH, 32'sd2);
      send_request(OP_MOD, '0);           // remainder follows dividend sign
      send_request(OP_PUSH, -32'sd9);
      send_request(OP_PUSH, 32'sd2);
      send_request(OP_DIV, '0);           // truncation toward zero
      send_request(OP_PUSH, MIN_VAL);
      send_request(OP_SUB, '0);
      send_request(OP_PUSH, MAX_VAL);
      send_request(OP_MUL, '0);
      send_request(OP_SPARE_HI, MIN_VAL);

      // random fill and drain sequences under each idling mix
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 79; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 79; end
            default: begin send_idle_pct = 29; stall_pct = 29; end
         endcase
         fill_len = $urandom_range(66, 70);
         for (int n = 0; n < fill_len + 90; n++) begin
            roll = $urandom_range(0, 99);
            if (n < fill_len || roll < 25) begin
               send_request(OP_PUSH, pick_value());
            end else if (roll < 93) begin
               send_request(pick_arith(), pick_value());
            end else begin
               send_request(roll[0] ? OP_SPARE_HI : OP_SPARE_LO, pick_value());
            end
         end
      end
      req_valid <= 1'b0;
      stall_pct = 0;

      // drain outstanding responses, then watch for stray ones
      while (board.pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display({"covered %0d transactions: push %0d add %0d sub %0d div %0d",
                " mul %0d mod %0d spare %0d"},
               board.checked_count, board.op_hits[OP_PUSH], board.op_hits[OP_ADD],
               board.op_hits[OP_SUB], board.op_hits[OP_DIV], board.op_hits[OP_MUL],
               board.op_hits[OP_MOD], board.op_hits[OP_SPARE_LO] + board.op_hits[OP_SPARE_HI]);
      $display("status ok %0d short %0d div-zero %0d full %0d, deepest stack %0d",
               board.status_hits[ST_OK], board.status_hits[ST_SHORT],
               board.status_hits[ST_DIVZERO], board.status_hits[ST_FULL], board.max_seen);
      if (board.error_count == 0 && board.pending_results.size() == 0) begin
         $display("stack_arithmetic_unit_core_tb OK");
      end else begin
         $display("stack_arithmetic_unit_core_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/sau_pkg.sv
design/sau_muldiv.sv
design/sau_datapath.sv
design/sau_ctrl.sv
design/stack_arithmetic_unit_core.sv
sim/stack_arithmetic_unit_core_tb.sv
